/* sv/ptrs_pkg.sv */
// ptrs_pkg: shared types, constants and helper functions for the pixel tint rotate scanner
// no dependencies; used by every module of the block by scoped names
package ptrs_pkg;

    // largest frame side handled by the scan counters
    localparam int MAX_DIM  = 512;
    localparam int CNT_W    = $clog2(MAX_DIM);
    localparam int DIM_W    = $clog2(MAX_DIM + 1);
    localparam int CMP_W    = DIM_W + 1;

    // fixed field widths
    localparam int CHAN_W   = 8;
    localparam int COORD_W  = 10;
    localparam int THR_W    = 9;
    localparam int TINT_W   = 24;
    localparam int TURN_W   = 2;
    localparam int FDIM_W   = 10;
    localparam int ORG_W    = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int CHAN_MAX = 255;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TINT            = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUARTER_TURNS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y        = 3'd6;

    // rotation codes
    localparam logic [TURN_W-1:0] TURN_0   = 2'd0;
    localparam logic [TURN_W-1:0] TURN_90  = 2'd1;
    localparam logic [TURN_W-1:0] TURN_180 = 2'd2;
    localparam logic [TURN_W-1:0] TURN_270 = 2'd3;

    // register reset values
    localparam logic [TINT_W-1:0] TINT_RESET   = 24'hFFFFFF;
    localparam logic [FDIM_W-1:0] WIDTH_RESET  = 10'd64;
    localparam logic [FDIM_W-1:0] HEIGHT_RESET = 10'd32;

    typedef logic [CHAN_W-1:0]  t_chan;
    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [DIM_W-1:0]   t_dim;

    // geometry seen by the coordinate mapper
    typedef struct packed {
        logic [TURN_W-1:0] turns;
        t_dim              width;
        t_dim              height;
        logic [ORG_W-1:0]  origin_x;
        logic [ORG_W-1:0]  origin_y;
    } t_geom;

    // zero side reads as one, oversized side saturates
    function automatic t_dim clamp_dim(logic [FDIM_W-1:0] v);
        t_dim res;
        if (v == '0) begin
            res = t_dim'(1);
        end else if (32'(v) > 32'(MAX_DIM)) begin
            res = t_dim'(MAX_DIM);
        end else begin
            res = t_dim'(v);
        end
        return res;
    endfunction

    // truncating divide by 255 for a product of two bytes
    function automatic t_chan div255(logic [2*CHAN_W-1:0] p);
        logic [2*CHAN_W-1:0] q;
        logic [2*CHAN_W-1:0] rem;
        q   = (p + (p >> CHAN_W)) >> CHAN_W;
        rem = p - ((q << CHAN_W) - q);
        if (rem >= (2*CHAN_W)'(CHAN_MAX)) begin
            q = q + 1'b1;
        end
        return q[CHAN_W-1:0];
    endfunction

endpackage

/* sv/pixel_tint_rotate_scanner_core.sv */
// pixel_tint_rotate_scanner_core: top level, config registers, scan counters and pipeline
// depends on ptrs_pkg, ptrs_shade, ptrs_coord
//
//  channel   valid / ready              payload
//  in        i_in_valid / o_in_ready    i_in_red, i_in_green, i_in_blue
//  out       o_out_valid / i_out_ready  o_dest_col, o_dest_row, o_out_red/green/blue
//  cfg       i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one beat per clock while the output is not stalled: an input register then a result register
// scan counters advance when an input beat is taken; black-after-scaling pixels are dropped
// synchronous active-low reset clears valids, counters and config registers
// a stalled output still lets one beat wait in the input register
module pixel_tint_rotate_scanner_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  ptrs_pkg::t_chan                     i_in_red,
    input  ptrs_pkg::t_chan                     i_in_green,
    input  ptrs_pkg::t_chan                     i_in_blue,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output ptrs_pkg::t_coord                    o_dest_col,
    output ptrs_pkg::t_coord                    o_dest_row,
    output ptrs_pkg::t_chan                     o_out_red,
    output ptrs_pkg::t_chan                     o_out_green,
    output ptrs_pkg::t_chan                     o_out_blue,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ptrs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ptrs_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic [ptrs_pkg::THR_W-1:0]  r_threshold;
    logic [ptrs_pkg::TINT_W-1:0] r_tint;
    logic [ptrs_pkg::TURN_W-1:0] r_turns;
    logic [ptrs_pkg::FDIM_W-1:0] r_frame_w;
    logic [ptrs_pkg::FDIM_W-1:0] r_frame_h;
    logic [ptrs_pkg::ORG_W-1:0]  r_origin_x;
    logic [ptrs_pkg::ORG_W-1:0]  r_origin_y;

    ptrs_pkg::t_cnt   r_scan_col;
    ptrs_pkg::t_cnt   r_scan_row;
    ptrs_pkg::t_cnt   n_scan_col;
    ptrs_pkg::t_cnt   n_scan_row;

    logic             r_s1_valid;
    ptrs_pkg::t_chan  r_s1_red;
    ptrs_pkg::t_chan  r_s1_green;
    ptrs_pkg::t_chan  r_s1_blue;
    ptrs_pkg::t_cnt   r_s1_col;
    ptrs_pkg::t_cnt   r_s1_row;

    logic             r_out_valid;
    ptrs_pkg::t_coord r_dest_col;
    ptrs_pkg::t_coord r_dest_row;
    ptrs_pkg::t_chan  r_out_red;
    ptrs_pkg::t_chan  r_out_green;
    ptrs_pkg::t_chan  r_out_blue;

    ptrs_pkg::t_geom  geom;
    ptrs_pkg::t_dim   scan_w;
    ptrs_pkg::t_dim   scan_h;
    logic             swap;
    logic             in_take;
    logic             s2_free;
    logic             cfg_take;

    ptrs_pkg::t_chan  sh_red;
    ptrs_pkg::t_chan  sh_green;
    ptrs_pkg::t_chan  sh_blue;
    logic             sh_nonzero;
    ptrs_pkg::t_coord map_col;
    ptrs_pkg::t_coord map_row;

    // handshakes
    assign o_cfg_ready = 1'b1;
    assign cfg_take    = i_cfg_valid && o_cfg_ready;
    assign s2_free     = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_s1_valid || s2_free;
    assign in_take     = i_in_valid && o_in_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
            r_tint      <= ptrs_pkg::TINT_RESET;
            r_turns     <= ptrs_pkg::TURN_0;
            r_frame_w   <= ptrs_pkg::WIDTH_RESET;
            r_frame_h   <= ptrs_pkg::HEIGHT_RESET;
            r_origin_x  <= '0;
            r_origin_y  <= '0;
        end else if (cfg_take) begin
            unique case (i_cfg_index)
                ptrs_pkg::CFG_NOISE_THRESHOLD: r_threshold <= i_cfg_data[ptrs_pkg::THR_W-1:0];
                ptrs_pkg::CFG_TINT:            r_tint      <= i_cfg_data[ptrs_pkg::TINT_W-1:0];
                ptrs_pkg::CFG_QUARTER_TURNS:   r_turns     <= i_cfg_data[ptrs_pkg::TURN_W-1:0];
                ptrs_pkg::CFG_FRAME_WIDTH:     r_frame_w   <= i_cfg_data[ptrs_pkg::FDIM_W-1:0];
                ptrs_pkg::CFG_FRAME_HEIGHT:    r_frame_h   <= i_cfg_data[ptrs_pkg::FDIM_W-1:0];
                ptrs_pkg::CFG_ORIGIN_X:        r_origin_x  <= i_cfg_data[ptrs_pkg::ORG_W-1:0];
                ptrs_pkg::CFG_ORIGIN_Y:        r_origin_y  <= i_cfg_data[ptrs_pkg::ORG_W-1:0];
                default: ;
            endcase
        end
    end

    // clamped geometry and scan frame size
    assign geom.turns    = r_turns;
    assign geom.width    = ptrs_pkg::clamp_dim(r_frame_w);
    assign geom.height   = ptrs_pkg::clamp_dim(r_frame_h);
    assign geom.origin_x = r_origin_x;
    assign geom.origin_y = r_origin_y;

    assign swap   = (r_turns == ptrs_pkg::TURN_90) || (r_turns == ptrs_pkg::TURN_270);
    assign scan_w = swap ? geom.height : geom.width;
    assign scan_h = swap ? geom.width  : geom.height;

    // raster counters over the rotated frame, wrapping at the end
    always_comb begin
        n_scan_col = r_scan_col;
        n_scan_row = r_scan_row;
        if (ptrs_pkg::CMP_W'(r_scan_col) + 1'b1 >= ptrs_pkg::CMP_W'(scan_w)) begin
            n_scan_col = '0;
            if (ptrs_pkg::CMP_W'(r_scan_row) + 1'b1 >= ptrs_pkg::CMP_W'(scan_h)) begin
                n_scan_row = '0;
            end else begin
                n_scan_row = r_scan_row + 1'b1;
            end
        end else begin
            n_scan_col = r_scan_col + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_col <= '0;
            r_scan_row <= '0;
        end else if (in_take) begin
            r_scan_col <= n_scan_col;
            r_scan_row <= n_scan_row;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_red   <= i_in_red;
            r_s1_green <= i_in_green;
            r_s1_blue  <= i_in_blue;
            r_s1_col   <= r_scan_col;
            r_s1_row   <= r_scan_row;
        end
    end

    // pixel shading and coordinate mapping
    ptrs_shade u_shade (
        .i_red       (r_s1_red),
        .i_green     (r_s1_green),
        .i_blue      (r_s1_blue),
        .i_threshold (r_threshold),
        .i_tint      (r_tint),
        .o_red       (sh_red),
        .o_green     (sh_green),
        .o_blue      (sh_blue),
        .o_nonzero   (sh_nonzero)
    );

    ptrs_coord u_coord (
        .i_geom     (geom),
        .i_scan_col (r_s1_col),
        .i_scan_row (r_s1_row),
        .o_col      (map_col),
        .o_row      (map_row)
    );

    // result register, black pixels are dropped here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_free) begin
            r_out_valid <= r_s1_valid && sh_nonzero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_free && r_s1_valid && sh_nonzero) begin
            r_dest_col  <= map_col;
            r_dest_row  <= map_row;
            r_out_red   <= sh_red;
            r_out_green <= sh_green;
            r_out_blue  <= sh_blue;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_dest_col  = r_dest_col;
    assign o_dest_row  = r_dest_row;
    assign o_out_red   = r_out_red;
    assign o_out_green = r_out_green;
    assign o_out_blue  = r_out_blue;

endmodule

/* sv/ptrs_shade.sv */
// ptrs_shade: noise gate and per-channel tint scaling of one pixel
// depends on ptrs_pkg
module ptrs_shade (
    input  ptrs_pkg::t_chan                  i_red,
    input  ptrs_pkg::t_chan                  i_green,
    input  ptrs_pkg::t_chan                  i_blue,
    input  logic [ptrs_pkg::THR_W-1:0]       i_threshold,
    input  logic [ptrs_pkg::TINT_W-1:0]      i_tint,
    output ptrs_pkg::t_chan                  o_red,
    output ptrs_pkg::t_chan                  o_green,
    output ptrs_pkg::t_chan                  o_blue,
    output logic                             o_nonzero
);

    logic                  dark;
    ptrs_pkg::t_chan       g_red;
    ptrs_pkg::t_chan       g_green;
    ptrs_pkg::t_chan       g_blue;
    logic [2*ptrs_pkg::CHAN_W-1:0] p_red;
    logic [2*ptrs_pkg::CHAN_W-1:0] p_green;
    logic [2*ptrs_pkg::CHAN_W-1:0] p_blue;

    // black when every channel sits below the threshold
    assign dark = (ptrs_pkg::THR_W'(i_red)   < i_threshold) &&
                  (ptrs_pkg::THR_W'(i_green) < i_threshold) &&
                  (ptrs_pkg::THR_W'(i_blue)  < i_threshold);

    assign g_red   = dark ? '0 : i_red;
    assign g_green = dark ? '0 : i_green;
    assign g_blue  = dark ? '0 : i_blue;

    // byte products against the tint limits
    assign p_red   = g_red   * i_tint[23:16];
    assign p_green = g_green * i_tint[15:8];
    assign p_blue  = g_blue  * i_tint[7:0];

    assign o_red   = ptrs_pkg::div255(p_red);
    assign o_green = ptrs_pkg::div255(p_green);
    assign o_blue  = ptrs_pkg::div255(p_blue);

    assign o_nonzero = (o_red != '0) || (o_green != '0) || (o_blue != '0);

endmodule

/* sv/ptrs_coord.sv */
// ptrs_coord: maps a scan position to a matrix coordinate for the selected rotation
// depends on ptrs_pkg
module ptrs_coord (
    input  ptrs_pkg::t_geom  i_geom,
    input  ptrs_pkg::t_cnt   i_scan_col,
    input  ptrs_pkg::t_cnt   i_scan_row,
    output ptrs_pkg::t_coord o_col,
    output ptrs_pkg::t_coord o_row
);

    ptrs_pkg::t_coord c;
    ptrs_pkg::t_coord r;
    ptrs_pkg::t_coord ox;
    ptrs_pkg::t_coord oy;
    ptrs_pkg::t_coord far_x;
    ptrs_pkg::t_coord far_y;

    // all arithmetic wraps at the coordinate width
    assign c     = ptrs_pkg::COORD_W'(i_scan_col);
    assign r     = ptrs_pkg::COORD_W'(i_scan_row);
    assign ox    = ptrs_pkg::COORD_W'(i_geom.origin_x);
    assign oy    = ptrs_pkg::COORD_W'(i_geom.origin_y);
    assign far_x = ptrs_pkg::COORD_W'(i_geom.width)  - 1'b1 + ox;
    assign far_y = ptrs_pkg::COORD_W'(i_geom.height) - 1'b1 + oy;

    // rotation select
    always_comb begin
        unique case (i_geom.turns)
            ptrs_pkg::TURN_90: begin
                o_col = far_x - r;
                o_row = c;
            end
            ptrs_pkg::TURN_180: begin
                o_col = far_x - c;
                o_row = far_y - r;
            end
            ptrs_pkg::TURN_270: begin
                o_col = r;
                o_row = far_y - c;
            end
            default: begin
                o_col = ox + c;
                o_row = oy + r;
            end
        endcase
    end

endmodule
